// File: hdl/bbro_pkg.sv
// Shared types, register indexes and the raster operation function of the bit blitter.
package bbro_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef enum logic [1:0] {
        ROP_COPY = 2'd0,
        ROP_AND  = 2'd1,
        ROP_OR   = 2'd2,
        ROP_XOR  = 2'd3
    } t_rop;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RASTER_OP      = 3'd0,
        CFG_SRC_BIT_OFFSET = 3'd1,
        CFG_DST_BIT_OFFSET = 3'd2,
        CFG_BIT_COUNT      = 3'd3,
        CFG_DESCENDING     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       src_only;
        logic [7:0] dst_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] dst_out;
        logic       last;
    } t_out_item;

    typedef struct packed {
        t_rop       raster_op;
        logic [2:0] src_bit_offset;
        logic [2:0] dst_bit_offset;
        logic       descending;
    } t_cfg;

    // Combine old destination with aligned source under the edge mask.
    function automatic logic [7:0] f_apply_op(
        input t_rop       op,
        input logic [7:0] oldv,
        input logic [7:0] v,
        input logic [7:0] m
    );
        logic [7:0] res;
        case (op)
            ROP_COPY: res = (oldv & ~m) | (v & m);
            ROP_AND:  res = oldv & (v | ~m);
            ROP_OR:   res = oldv | (v & m);
            ROP_XOR:  res = oldv ^ (v & m);
            default:  res = oldv;
        endcase
        return res;
    endfunction

endpackage

// File: hdl/bit_blit_raster_op.sv
// Top level of the streaming monochrome bit blitter with raster operations.
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  -----------------------------------
//  in       to block   i_in_valid / o_in_stall    t_in_item: src_byte, src_only, dst
//  out      from block o_out_valid / i_out_stall  t_out_item: dst_out, last
//  cfg      to block   i_cfg_valid / o_cfg_ready  register index and write data
//
// Every input transaction passes through the input register and then through the
// funnel, mask and raster logic into the output register before its result is
// visible. One transaction is accepted every cycle as long as the output side keeps
// up; the run state (previous source byte, bits remaining, first byte flag) is
// updated in the same cycle the item leaves the input register.
// Reset is synchronous and active low; it resets the configuration and run state and
// clears the valid flags, but not the data registers. A stall on the output holds the
// result and, once the input register is also full, stalls the input side. Source-only
// items never wait for the output side, since they produce no result.
module bit_blit_raster_op
    import bbro_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers.
    t_cfg                  r_cfg;
    logic [COUNT_BITS-1:0] r_bit_count;

    // Run state carried from one destination byte to the next.
    logic [7:0]            r_prev_source;
    logic [COUNT_BITS-1:0] r_bits_remaining;
    logic                  r_at_first;

    // Input register stage and output register stage.
    logic                  r_s1_valid;
    t_in_item              r_s1;
    logic                  r_out_valid;
    t_out_item             r_out;

    t_out_item             w_result;
    logic [COUNT_BITS-1:0] n_bits_remaining;
    logic                  w_out_free;
    logic                  w_fire;

    // The output register can take a new result when it is empty or being drained.
    assign w_out_free = !r_out_valid || !i_out_stall;
    // A source-only item just primes the funnel, so it never waits on the output.
    assign w_fire     = r_s1_valid && (r_s1.src_only || w_out_free);
    assign o_in_stall = r_s1_valid && !w_fire;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    bbro_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_cfg            (r_cfg),
        .i_bit_count      (r_bit_count),
        .i_prev_source    (r_prev_source),
        .i_bits_remaining (r_bits_remaining),
        .i_at_first       (r_at_first),
        .i_item           (r_s1),
        .o_result         (w_result),
        .o_bits_remaining (n_bits_remaining)
    );

    // Configuration writes; indexes past the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raster_op      <= ROP_COPY;
            r_cfg.src_bit_offset <= 3'd0;
            r_cfg.dst_bit_offset <= 3'd0;
            r_cfg.descending     <= 1'b0;
            r_bit_count          <= COUNT_BITS'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RASTER_OP:      r_cfg.raster_op      <= t_rop'(i_cfg_data[1:0]);
                CFG_SRC_BIT_OFFSET: r_cfg.src_bit_offset <= i_cfg_data[2:0];
                CFG_DST_BIT_OFFSET: r_cfg.dst_bit_offset <= i_cfg_data[2:0];
                CFG_BIT_COUNT:      r_bit_count          <= COUNT_BITS'(i_cfg_data);
                CFG_DESCENDING:     r_cfg.descending     <= i_cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Input register: loads whenever it is empty or its item moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1 <= i_in_data;
        end
    end

    // Run state advances as each item leaves the input register. A source-only
    // item only replaces the previous source byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_source    <= 8'd0;
            r_bits_remaining <= '0;
            r_at_first       <= 1'b1;
        end else if (w_fire) begin
            r_prev_source <= r_s1.src_byte;
            if (!r_s1.src_only) begin
                r_bits_remaining <= n_bits_remaining;
                r_at_first       <= w_result.last;
            end
        end
    end

    // Output register with its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && !r_s1.src_only) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && !r_s1.src_only) begin
            r_out <= w_result;
        end
    end

endmodule

// File: hdl/bbro_datapath.sv
// Funnel shifter, edge mask and raster operation for one destination byte.
module bbro_datapath
    import bbro_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  t_cfg                  i_cfg,
    input  logic [COUNT_BITS-1:0] i_bit_count,
    input  logic [7:0]            i_prev_source,
    input  logic [COUNT_BITS-1:0] i_bits_remaining,
    input  logic                  i_at_first,
    input  t_in_item              i_item,
    output t_out_item             o_result,
    output logic [COUNT_BITS-1:0] o_bits_remaining
);

    logic [2:0]            w_sh;
    logic [3:0]            w_sh_desc;
    logic [15:0]           w_funnel_asc;
    logic [15:0]           w_funnel_desc;
    logic [7:0]            w_v;
    logic [3:0]            w_lead;
    logic [2:0]            w_lead_desc;
    logic [COUNT_BITS-1:0] w_lead_ext;
    logic [COUNT_BITS-1:0] w_lead_gap;
    logic [3:0]            w_gap;
    logic [7:0]            w_m;
    logic [COUNT_BITS-1:0] w_rem;

    always_comb begin
        // Funnel alignment of the previous and current source bytes.
        w_sh          = i_cfg.dst_bit_offset - i_cfg.src_bit_offset;
        w_sh_desc     = (w_sh == 3'd0) ? 4'd8 : {1'b0, w_sh};
        w_funnel_asc  = {i_prev_source, i_item.src_byte} >> w_sh;
        w_funnel_desc = {i_item.src_byte, i_prev_source} >> w_sh_desc;
        w_v           = i_cfg.descending ? w_funnel_desc[7:0] : w_funnel_asc[7:0];

        // Bits that the first byte of the run can hold.
        w_lead_desc = i_cfg.dst_bit_offset + i_bit_count[2:0];
        if (i_cfg.descending) begin
            w_lead = (w_lead_desc == 3'd0) ? 4'd8 : {1'b0, w_lead_desc};
        end else begin
            w_lead = 4'd8 - {1'b0, i_cfg.dst_bit_offset};
        end
        w_lead_ext = COUNT_BITS'(w_lead);
        w_lead_gap = w_lead_ext - i_bit_count;
        w_gap      = 4'd8 - {1'b0, i_bits_remaining[2:0]};

        if (i_at_first) begin
            if (i_cfg.descending) begin
                w_m = BYTE_ONES << (4'd8 - w_lead);
            end else begin
                w_m = BYTE_ONES >> i_cfg.dst_bit_offset;
            end
            if (i_bit_count < w_lead_ext) begin
                // The whole run fits inside the first byte: trim the far edge too.
                if (i_cfg.descending) begin
                    w_m = w_m & (BYTE_ONES >> w_lead_gap[3:0]);
                end else begin
                    w_m = w_m & (BYTE_ONES << w_lead_gap[3:0]);
                end
                w_rem = '0;
            end else begin
                w_rem = i_bit_count - w_lead_ext;
            end
        end else if (i_bits_remaining >= COUNT_BITS'(8)) begin
            w_m   = BYTE_ONES;
            w_rem = i_bits_remaining - COUNT_BITS'(8);
        end else begin
            // Closing partial byte.
            w_m   = i_cfg.descending ? (BYTE_ONES >> w_gap) : (BYTE_ONES << w_gap);
            w_rem = '0;
        end
    end

    assign o_result.dst_out = f_apply_op(i_cfg.raster_op, i_item.dst_byte, w_v, w_m);
    assign o_result.last    = (w_rem == '0);
    assign o_bits_remaining = w_rem;

endmodule
